// ===== hw/rtl/xte_pkg.sv =====
// Shared types, codes and character tables for the XML text escaper.
package xte_pkg;

  localparam int CP_W   = 32;  // input code unit width
  localparam int CHAR_W = 21;  // emitted code point width
  localparam int POS_W  = 32;  // position counter width
  localparam int IDX_W  = 3;   // index into an entity sequence (up to six)

  // Characters that are replaced by entities
  localparam logic [CP_W-1:0] CP_AMP  = 32'h0000_0026;
  localparam logic [CP_W-1:0] CP_LT   = 32'h0000_003C;
  localparam logic [CP_W-1:0] CP_GT   = 32'h0000_003E;
  localparam logic [CP_W-1:0] CP_QUOT = 32'h0000_0022;
  localparam logic [CP_W-1:0] CP_APOS = 32'h0000_0027;

  // Bounds of the valid XML character set
  localparam logic [CP_W-1:0] CP_TAB       = 32'h0000_0009;
  localparam logic [CP_W-1:0] CP_LF        = 32'h0000_000A;
  localparam logic [CP_W-1:0] CP_CR        = 32'h0000_000D;
  localparam logic [CP_W-1:0] CP_BMP_LO    = 32'h0000_0020;
  localparam logic [CP_W-1:0] CP_BMP_HI    = 32'h0000_D7FF;
  localparam logic [CP_W-1:0] CP_PRIV_LO   = 32'h0000_E000;
  localparam logic [CP_W-1:0] CP_PRIV_HI   = 32'h0000_FFFD;
  localparam logic [CP_W-1:0] CP_SUPP_LO   = 32'h0001_0000;
  localparam logic [CP_W-1:0] CP_SUPP_HI   = 32'h0010_FFFF;

  // Bit places of the flags in the output tuser
  localparam int USER_VALID = 0;
  localparam int USER_LAST  = 1;
  localparam int USER_ERROR = 2;
  localparam int USER_W     = 3;

  // Work codes passed from the classifier to the expander
  typedef enum logic [2:0] {
    OP_CHAR  = 3'd0,
    OP_AMP   = 3'd1,
    OP_LT    = 3'd2,
    OP_GT    = 3'd3,
    OP_QUOT  = 3'd4,
    OP_APOS  = 3'd5,
    OP_MARK  = 3'd6,
    OP_ERROR = 3'd7
  } op_t;

  typedef logic [IDX_W-1:0] idx_t;

  // One queued command: what to emit for one input item
  typedef struct packed {
    op_t               op;
    logic [CHAR_W-1:0] ch;
    logic              done;  // last result closes the string
    logic [POS_W-1:0]  pos;
    logic [CP_W-1:0]   bad;
  } cmd_t;

  // One result item
  typedef struct packed {
    logic [CHAR_W-1:0] out_char;
    logic              char_valid;
    logic              last_of_item;
    logic              string_done;
    logic              error;
    logic [POS_W-1:0]  error_position;
    logic [CP_W-1:0]   bad_code_point;
  } res_t;

  // Number of results a command produces
  function automatic idx_t op_len(op_t op);
    idx_t len;
    unique case (op) inside
      OP_AMP:                        len = IDX_W'(5);
      OP_LT, OP_GT:                  len = IDX_W'(4);
      OP_QUOT, OP_APOS:              len = IDX_W'(6);
      OP_CHAR, OP_MARK, OP_ERROR:    len = IDX_W'(1);
      default:                       len = IDX_W'(1);
    endcase
    return len;
  endfunction

  // Character number idx of an entity sequence
  function automatic logic [CHAR_W-1:0] ent_char(op_t op, idx_t idx);
    logic [7:0] c;
    c = 8'h26;
    unique case (op)
      OP_AMP: begin
        unique case (idx)
          3'd0:    c = 8'h26;
          3'd1:    c = 8'h61;
          3'd2:    c = 8'h6D;
          3'd3:    c = 8'h70;
          default: c = 8'h3B;
        endcase
      end
      OP_LT: begin
        unique case (idx)
          3'd0:    c = 8'h26;
          3'd1:    c = 8'h6C;
          3'd2:    c = 8'h74;
          default: c = 8'h3B;
        endcase
      end
      OP_GT: begin
        unique case (idx)
          3'd0:    c = 8'h26;
          3'd1:    c = 8'h67;
          3'd2:    c = 8'h74;
          default: c = 8'h3B;
        endcase
      end
      OP_QUOT: begin
        unique case (idx)
          3'd0:    c = 8'h26;
          3'd1:    c = 8'h71;
          3'd2:    c = 8'h75;
          3'd3:    c = 8'h6F;
          3'd4:    c = 8'h74;
          default: c = 8'h3B;
        endcase
      end
      OP_APOS: begin
        unique case (idx)
          3'd0:    c = 8'h26;
          3'd1:    c = 8'h61;
          3'd2:    c = 8'h70;
          3'd3:    c = 8'h6F;
          3'd4:    c = 8'h73;
          default: c = 8'h3B;
        endcase
      end
      default: c = 8'h26;
    endcase
    return CHAR_W'(c);
  endfunction

  // Valid XML character test
  function automatic logic xml_char_ok(logic [CP_W-1:0] c);
    return (c == CP_TAB) || (c == CP_LF) || (c == CP_CR) ||
           ((c >= CP_BMP_LO) && (c <= CP_BMP_HI)) ||
           ((c >= CP_PRIV_LO) && (c <= CP_PRIV_HI)) ||
           ((c >= CP_SUPP_LO) && (c <= CP_SUPP_HI));
  endfunction

endpackage

// ===== hw/rtl/xte_front.sv =====
// Front end: accepts code points, tracks string position and abort, classifies.
module xte_front
  import xte_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            invalid_policy,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [CP_W-1:0] code_point,
  input  logic            end_of_string,
  input  logic            q_full,
  output logic            push,
  output cmd_t            cmd
);

  logic [POS_W-1:0] position;
  logic [POS_W-1:0] position_next;
  logic             aborted;
  logic             aborted_next;
  logic             emit;
  logic             accept;

  // Take an item whenever the queue has room
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && emit;

  // Classify the code point and work out the next string state
  always_comb begin
    cmd.op        = OP_CHAR;
    cmd.ch        = code_point[CHAR_W-1:0];
    cmd.done      = end_of_string;
    cmd.pos       = position;
    cmd.bad       = code_point;
    emit          = 1'b0;
    aborted_next  = aborted;
    position_next = end_of_string ? '0 : position + POS_W'(1);
    if (aborted) begin
      aborted_next = !end_of_string;
    end else begin
      unique case (code_point)
        CP_AMP: begin
          cmd.op = OP_AMP;
          emit   = 1'b1;
        end
        CP_LT: begin
          cmd.op = OP_LT;
          emit   = 1'b1;
        end
        CP_GT: begin
          cmd.op = OP_GT;
          emit   = 1'b1;
        end
        CP_QUOT: begin
          cmd.op = OP_QUOT;
          emit   = 1'b1;
        end
        CP_APOS: begin
          cmd.op = OP_APOS;
          emit   = 1'b1;
        end
        default: begin
          if (xml_char_ok(code_point)) begin
            cmd.op = OP_CHAR;
            emit   = 1'b1;
          end else if (invalid_policy) begin
            // Report once, then drop the rest of the string
            cmd.op       = OP_ERROR;
            cmd.done     = 1'b1;
            emit         = 1'b1;
            aborted_next = !end_of_string;
          end else if (end_of_string) begin
            cmd.op = OP_MARK;
            emit   = 1'b1;
          end
        end
      endcase
    end
  end

  // Advance the string state on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
      aborted  <= 1'b0;
    end else if (accept) begin
      position <= position_next;
      aborted  <= aborted_next;
    end
  end

endmodule

// ===== hw/rtl/xte_queue.sv =====
// Command queue between the classifier and the expander.
module xte_queue
  import xte_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t wr_cmd,
  input  logic pop,
  output cmd_t head,
  output logic empty,
  output logic full
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign empty = (count == '0);
  assign full  = (count == CNT_W'(DEPTH));
  assign head  = entries[rd_ptr];

  // Write the entry at the tail
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_cmd;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/xte_back.sv =====
// Back end: expands queued commands into result items behind an output register.
module xte_back
  import xte_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  cmd_t head,
  input  logic q_empty,
  output logic pop,
  output logic out_valid,
  input  logic out_ready,
  output res_t res
);

  idx_t idx;
  logic load;
  logic fire;
  logic at_end;
  res_t res_next;

  // Load a new result when the register is free or being drained
  assign load   = !out_valid || out_ready;
  assign fire   = load && !q_empty;
  assign at_end = (idx == op_len(head.op) - IDX_W'(1));
  assign pop    = fire && at_end;

  // Build the result for the current step of the head command
  always_comb begin
    res_next                = '0;
    res_next.last_of_item   = at_end;
    res_next.string_done    = at_end && head.done;
    unique case (head.op) inside
      OP_CHAR: begin
        res_next.out_char   = head.ch;
        res_next.char_valid = 1'b1;
      end
      OP_AMP, OP_LT, OP_GT, OP_QUOT, OP_APOS: begin
        res_next.out_char   = ent_char(head.op, idx);
        res_next.char_valid = 1'b1;
      end
      OP_ERROR: begin
        res_next.error          = 1'b1;
        res_next.error_position = head.pos;
        res_next.bad_code_point = head.bad;
      end
      default: begin
        res_next.char_valid = 1'b0;
      end
    endcase
  end

  // Step through the sequence and hold the output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= fire;
      if (fire) begin
        idx <= at_end ? '0 : idx + IDX_W'(1);
      end
    end
  end

  // Capture the result payload
  always_ff @(posedge clk) begin
    if (fire) begin
      res <= res_next;
    end
  end

endmodule

// ===== hw/rtl/xml_text_escaper.sv =====
// XML text escaper: entity expansion and character validation of a code point stream.
//
// Input stream s_axis carries one 32-bit code point per transfer; s_axis_tlast
// marks the last code point of a string. Output stream m_axis carries one
// escaped character or marker per transfer; m_axis_tlast closes the string.
// & < > " ' expand into four to six characters, other valid XML characters
// pass unchanged, invalid ones are dropped or reported as cfg_data selects.
// A report carries the position and code point and ends the string; the rest
// of that string is then consumed without results.
// The first result of an item is registered in the command queue after its input
// transfer, and then in the output register.
// Throughput: one item per cycle while each yields one result and m_axis is ready;
// an entity holds the expander until all of its characters are out, and the
// classifier keeps accepting until the QUEUE_DEPTH-entry command queue fills.
// A stalled m_axis holds its result and backs up through the queue to s_axis.
// Reset clears the string position, the abort flag, the queue and the policy
// (drop invalid code points). Write cfg only while the block is idle.
module xml_text_escaper
  import xte_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  // Policy register write
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic          cfg_data,        // invalid_policy
  // Input stream
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [31:0]   s_axis_tdata,    // code_point[31:0]
  input  logic          s_axis_tlast,    // end_of_string
  // Output stream
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [87:0]   m_axis_tdata,    // out_char[20:0], error_position[52:21],
                                         // bad_code_point[84:53], zero pad[87:85]
  output logic [USER_W-1:0] m_axis_tuser, // char_valid[0], last_of_item[1], error[2]
  output logic          m_axis_tlast     // string_done
);

  logic invalid_policy;
  logic q_push;
  logic q_pop;
  logic q_empty;
  logic q_full;
  cmd_t q_wr;
  cmd_t q_head;
  res_t res;

  // Hold the policy register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      invalid_policy <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      invalid_policy <= cfg_data;
    end
  end

  xte_front u_front (
    .clk            (clk),
    .rst            (rst),
    .invalid_policy (invalid_policy),
    .in_valid       (s_axis_tvalid),
    .in_ready       (s_axis_tready),
    .code_point     (s_axis_tdata),
    .end_of_string  (s_axis_tlast),
    .q_full         (q_full),
    .push           (q_push),
    .cmd            (q_wr)
  );

  xte_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .wr_cmd (q_wr),
    .pop    (q_pop),
    .head   (q_head),
    .empty  (q_empty),
    .full   (q_full)
  );

  xte_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (q_head),
    .q_empty   (q_empty),
    .pop       (q_pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .res       (res)
  );

  // Pack the result onto the output stream
  assign m_axis_tdata = {3'b000, res.bad_code_point, res.error_position, res.out_char};
  assign m_axis_tuser = {res.error, res.last_of_item, res.char_valid};
  assign m_axis_tlast = res.string_done;

`ifndef SYNTHESIS
  // The classifier never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(q_push && q_full))
    else $error("command pushed into full queue");

  // An error report always closes the item and the string
  a_error_closes: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[USER_ERROR]) |->
      (m_axis_tuser[USER_LAST] && m_axis_tlast && !m_axis_tuser[USER_VALID]))
    else $error("error report not marked as end of string");

  // A result without a character is a marker or an error report and ends its string
  a_marker_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser[USER_VALID]) |->
      (m_axis_tuser[USER_LAST] && m_axis_tlast))
    else $error("marker result not last of its string");

  // No result is shown in the cycle after reset
  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid)
    else $error("output valid right after reset");
`endif

endmodule
